/* src/dpm_pkg.sv */
// ----------------------------------------------------------------------------
// dpm_pkg: shared types and constants for the demand-paging MMU
// Sizes of the page table, item kinds, status codes and sequencer states.
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int VIRTUAL_PAGES = 64;
    localparam int PAGE_W        = 6;
    localparam int OFFSET_WIDTH  = 8;
    localparam int VA_W          = 14;
    localparam int PHYS_FRAMES   = 16;
    localparam int FRAME_W       = 4;
    localparam int PA_W          = 12;
    localparam int SWAP_SLOTS    = 1024;
    localparam int SLOT_W        = 10;
    localparam int NEXT_SLOT_W   = 11;
    localparam int TIME_W        = 32;

    typedef enum logic [2:0] {
        K_TRANSLATE = 3'd0,
        K_MAP       = 3'd1,
        K_UNMAP     = 3'd2,
        K_ALLOC     = 3'd3,
        K_FREE      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_FRAME  = 2'd2,
        ST_SWAP_FULL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TR_HIT,
        S_UNMAP_RD,
        S_SCAN,
        S_SCAN_END,
        S_VICTIM,
        S_VSLOT,
        S_EVICT,
        S_COMMIT,
        S_PSLOT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]         status;
        logic [PA_W-1:0]    physical_address;
        logic [FRAME_W-1:0] frame;
        logic               page_fault;
        logic               fill_from_swap;
        logic [SLOT_W-1:0]  fill_slot;
        logic               evicted;
        logic [FRAME_W-1:0] victim_frame;
        logic               writeback;
        logic [SLOT_W-1:0]  writeback_slot;
    } t_result;

endpackage

/* src/dpm_ram.sv */
// ----------------------------------------------------------------------------
// dpm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/demand_paging_mmu_lru_top.sv */
// A map, free or unmapped translate goes from dispatch to the result state; a translate
// hit or unmap passes S_TR_HIT or S_UNMAP_RD, a free-frame fault or allocate S_COMMIT.
// An eviction walks all 64 pages through the frame and time RAMs, one page per cycle
// on one shared comparator.
// One item at a time; the next item is taken in the cycle after its result is loaded.
// Sync active-low reset clears page flags and protection, frees all frames, zeroes slot count.
// ----------------------------------------------------------------------------
// demand_paging_mmu_lru_top: page-table engine with LRU replacement
// Translates accesses, maps and unmaps pages, and hands out and frees frames, evicting
// the least-recently-used unprotected resident page when none is free.
// ----------------------------------------------------------------------------
module demand_paging_mmu_lru_top
    import dpm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_kind,
    input  logic [VA_W-1:0]     i_virtual_address,
    input  logic                i_is_write,
    input  logic [PAGE_W-1:0]   i_virtual_page,
    input  logic [FRAME_W-1:0]  i_physical_page,
    input  logic [TIME_W-1:0]   i_current_time,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [PA_W-1:0]     o_physical_address,
    output logic [FRAME_W-1:0]  o_frame,
    output logic                o_page_fault,
    output logic                o_fill_from_swap,
    output logic [SLOT_W-1:0]   o_fill_slot,
    output logic                o_evicted,
    output logic [FRAME_W-1:0]  o_victim_frame,
    output logic                o_writeback,
    output logic [SLOT_W-1:0]   o_writeback_slot
);

    t_state r_state, n_state;

    logic [PHYS_FRAMES-1:0]   r_prot;
    logic [VIRTUAL_PAGES-1:0] r_mapped, n_mapped;
    logic [VIRTUAL_PAGES-1:0] r_resident, n_resident;
    logic [VIRTUAL_PAGES-1:0] r_dirty, n_dirty;
    logic [VIRTUAL_PAGES-1:0] r_has_slot, n_has_slot;
    logic [PHYS_FRAMES-1:0]   r_free, n_free;
    logic [NEXT_SLOT_W-1:0]   r_next_slot, n_next_slot;

    // Latched item.
    logic [2:0]          r_kind;
    logic [VA_W-1:0]     r_va;
    logic                r_wr;
    logic [PAGE_W-1:0]   r_vp;
    logic [FRAME_W-1:0]  r_pp;
    logic [TIME_W-1:0]   r_now;

    // Scan and frame selection.
    logic [PAGE_W-1:0]   r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [PAGE_W-1:0]   r_cmp_idx;
    logic                r_found, n_found;
    logic [TIME_W-1:0]   r_best, n_best;
    logic [PAGE_W-1:0]   r_victim, n_victim;
    logic [FRAME_W-1:0]  r_best_frame, n_best_frame;
    logic [FRAME_W-1:0]  r_f, n_f;

    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_valid;

    // RAM ports.
    logic                frame_we, time_we, slot_we;
    logic [PAGE_W-1:0]   frame_waddr, time_waddr, slot_waddr;
    logic [PAGE_W-1:0]   frame_raddr, slot_raddr;
    logic [FRAME_W-1:0]  frame_wdata, frame_rdata;
    logic [TIME_W-1:0]   time_wdata, time_rdata;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;

    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  low_free;
    logic                any_free;
    logic                cand;
    logic                in_acc;
    logic                res_load;

    assign page     = r_va[VA_W-1 -: PAGE_W];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign res_load = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        low_free = '0;
        for (int k = PHYS_FRAMES - 1; k >= 0; k--) begin
            if (r_free[k]) begin
                low_free = FRAME_W'(k);
            end
        end
    end
    assign any_free = |r_free;

    // One shared comparator judges the page whose RAM data just came back.
    assign cand = r_cmp_vld && r_mapped[r_cmp_idx] && r_resident[r_cmp_idx]
                  && !r_prot[frame_rdata] && (!r_found || (time_rdata < r_best));

    dpm_ram #(.WIDTH(FRAME_W), .DEPTH(VIRTUAL_PAGES)) u_frame_ram (
        .i_clk(i_clk), .i_we(frame_we), .i_waddr(frame_waddr), .i_wdata(frame_wdata),
        .i_raddr(frame_raddr), .o_rdata(frame_rdata)
    );

    dpm_ram #(.WIDTH(TIME_W), .DEPTH(VIRTUAL_PAGES)) u_time_ram (
        .i_clk(i_clk), .i_we(time_we), .i_waddr(time_waddr), .i_wdata(time_wdata),
        .i_raddr(r_idx), .o_rdata(time_rdata)
    );

    dpm_ram #(.WIDTH(SLOT_W), .DEPTH(VIRTUAL_PAGES)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (r_kind == K_TRANSLATE && !r_mapped[page]) begin
                    n_state = S_RESULT;
                end else if (r_kind == K_TRANSLATE && r_resident[page]) begin
                    n_state = S_TR_HIT;
                end else if (r_kind == K_TRANSLATE || r_kind == K_ALLOC) begin
                    n_state = any_free ? S_COMMIT : S_SCAN;
                end else if (r_kind == K_UNMAP) begin
                    n_state = S_UNMAP_RD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_TR_HIT:   n_state = S_RESULT;
            S_UNMAP_RD: n_state = S_RESULT;
            S_SCAN: begin
                if (r_idx == PAGE_W'(VIRTUAL_PAGES - 1)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: n_state = S_VICTIM;
            S_VICTIM: begin
                priority if (!r_found) begin
                    n_state = S_RESULT;
                end else if (r_dirty[r_victim] && !r_has_slot[r_victim]) begin
                    n_state = (r_next_slot >= NEXT_SLOT_W'(SWAP_SLOTS)) ? S_RESULT : S_EVICT;
                end else if (r_dirty[r_victim]) begin
                    n_state = S_VSLOT;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_VSLOT:  n_state = S_EVICT;
            S_EVICT:  n_state = S_COMMIT;
            S_COMMIT: begin
                n_state = (r_kind == K_TRANSLATE && r_has_slot[page]) ? S_PSLOT : S_RESULT;
            end
            S_PSLOT:  n_state = S_RESULT;
            S_RESULT: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_mapped     = r_mapped;
        n_resident   = r_resident;
        n_dirty      = r_dirty;
        n_has_slot   = r_has_slot;
        n_free       = r_free;
        n_next_slot  = r_next_slot;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_found      = r_found;
        n_best       = r_best;
        n_victim     = r_victim;
        n_best_frame = r_best_frame;
        n_f          = r_f;
        n_res        = r_res;
        frame_we     = 1'b0;
        frame_waddr  = page;
        frame_wdata  = r_f;
        frame_raddr  = r_idx;
        time_we      = 1'b0;
        time_waddr   = page;
        time_wdata   = r_now;
        slot_we      = 1'b0;
        slot_waddr   = r_victim;
        slot_wdata   = r_next_slot[SLOT_W-1:0];
        slot_raddr   = r_victim;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                end
            end
            S_DISPATCH: begin
                frame_raddr = (r_kind == K_UNMAP) ? r_vp : page;
                n_idx   = '0;
                n_found = 1'b0;
                priority if (r_kind == K_TRANSLATE && !r_mapped[page]) begin
                    n_res.status = ST_NOT_MAPPED;
                end else if (r_kind == K_TRANSLATE && r_resident[page]) begin
                    n_res.status = ST_OK;
                end else if (r_kind == K_TRANSLATE || r_kind == K_ALLOC) begin
                    if (any_free) begin
                        n_f = low_free;
                        n_free[low_free] = 1'b0;
                    end
                end else if (r_kind == K_MAP) begin
                    n_mapped[r_vp]   = 1'b1;
                    n_resident[r_vp] = 1'b1;
                    n_dirty[r_vp]    = 1'b0;
                    n_free[r_pp]     = 1'b0;
                    frame_we    = 1'b1;
                    frame_waddr = r_vp;
                    frame_wdata = r_pp;
                    time_we     = 1'b1;
                    time_waddr  = r_vp;
                end else if (r_kind == K_FREE) begin
                    n_free[r_pp] = 1'b1;
                end else begin
                    n_res = '0;
                end
            end
            S_TR_HIT: begin
                time_we = 1'b1;
                if (r_wr) begin
                    n_dirty[page] = 1'b1;
                end
                n_res.physical_address = {frame_rdata, r_va[OFFSET_WIDTH-1:0]};
                n_res.frame            = frame_rdata;
            end
            S_UNMAP_RD: begin
                if (r_mapped[r_vp] && r_resident[r_vp]) begin
                    n_free[frame_rdata] = 1'b1;
                end
                n_mapped[r_vp]   = 1'b0;
                n_resident[r_vp] = 1'b0;
                n_dirty[r_vp]    = 1'b0;
                n_has_slot[r_vp] = 1'b0;
            end
            S_SCAN, S_SCAN_END: begin
                n_cmp_vld = (r_state == S_SCAN);
                if (r_state == S_SCAN) begin
                    n_idx = r_idx + PAGE_W'(1);
                end
                if (cand) begin
                    n_found      = 1'b1;
                    n_best       = time_rdata;
                    n_victim     = r_cmp_idx;
                    n_best_frame = frame_rdata;
                end
            end
            S_VICTIM: begin
                priority if (!r_found) begin
                    n_res.status = ST_NO_FRAME;
                end else if (r_dirty[r_victim] && !r_has_slot[r_victim]) begin
                    if (r_next_slot >= NEXT_SLOT_W'(SWAP_SLOTS)) begin
                        n_res.status = ST_SWAP_FULL;
                    end else begin
                        slot_we                 = 1'b1;
                        n_has_slot[r_victim]    = 1'b1;
                        n_next_slot             = r_next_slot + NEXT_SLOT_W'(1);
                        n_res.writeback         = 1'b1;
                        n_res.writeback_slot    = r_next_slot[SLOT_W-1:0];
                    end
                end else begin
                    n_res.status = ST_OK;
                end
            end
            S_VSLOT: begin
                n_res.writeback      = 1'b1;
                n_res.writeback_slot = slot_rdata;
            end
            S_EVICT: begin
                n_resident[r_victim] = 1'b0;
                n_dirty[r_victim]    = 1'b0;
                n_res.evicted        = 1'b1;
                n_res.victim_frame   = r_best_frame;
                n_f                  = r_best_frame;
            end
            S_COMMIT: begin
                slot_raddr = page;
                n_res.frame = r_f;
                if (r_kind == K_TRANSLATE) begin
                    frame_we          = 1'b1;
                    time_we           = 1'b1;
                    n_resident[page]  = 1'b1;
                    n_dirty[page]     = r_wr;
                    n_res.page_fault  = 1'b1;
                    n_res.physical_address = {r_f, r_va[OFFSET_WIDTH-1:0]};
                end
            end
            S_PSLOT: begin
                n_res.fill_from_swap = 1'b1;
                n_res.fill_slot      = slot_rdata;
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prot      <= '0;
            r_mapped    <= '0;
            r_resident  <= '0;
            r_dirty     <= '0;
            r_has_slot  <= '0;
            r_free      <= '1;
            r_next_slot <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_prot <= i_cfg_data;
            end
            r_mapped    <= n_mapped;
            r_resident  <= n_resident;
            r_dirty     <= n_dirty;
            r_has_slot  <= n_has_slot;
            r_free      <= n_free;
            r_next_slot <= n_next_slot;
            r_cmp_vld   <= n_cmp_vld;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_va   <= i_virtual_address;
            r_wr   <= i_is_write;
            r_vp   <= i_virtual_page;
            r_pp   <= i_physical_page;
            r_now  <= i_current_time;
        end
        r_idx        <= n_idx;
        r_cmp_idx    <= r_idx;
        r_found      <= n_found;
        r_best       <= n_best;
        r_victim     <= n_victim;
        r_best_frame <= n_best_frame;
        r_f          <= n_f;
        r_res        <= n_res;
        if (res_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_physical_address = r_out.physical_address;
    assign o_frame            = r_out.frame;
    assign o_page_fault       = r_out.page_fault;
    assign o_fill_from_swap   = r_out.fill_from_swap;
    assign o_fill_slot        = r_out.fill_slot;
    assign o_evicted          = r_out.evicted;
    assign o_victim_frame     = r_out.victim_frame;
    assign o_writeback        = r_out.writeback;
    assign o_writeback_slot   = r_out.writeback_slot;

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_slot <= NEXT_SLOT_W'(SWAP_SLOTS))
        else $error("swap slot counter overran");

    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.writeback |-> r_out.evicted && r_out.status == ST_OK)
        else $error("writeback without eviction");

    a_scan_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> r_state == S_SCAN || r_state == S_SCAN_END)
        else $error("scan left early");

    a_resident_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVICT |-> r_mapped[r_victim] && r_resident[r_victim])
        else $error("victim not a mapped resident page");

endmodule
